// ===== design/mi3_pkg.sv =====
package mi3_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int NUM_ENT    = 9;

  localparam int PROD_W  = 2 * DATA_WIDTH;
  localparam int COF_W   = PROD_W + 1;
  localparam int DET_W   = 3 * DATA_WIDTH + 3;
  localparam int NUM_W   = COF_W + 2 * FRAC_BITS;
  localparam int REM_A   = DET_W + DATA_WIDTH + 1;
  localparam int REM_W   = (NUM_W + 1 > REM_A) ? NUM_W + 1 : REM_A;
  localparam int TDATA_W = ((NUM_ENT * DATA_WIDTH + 7) / 8) * 8;

  // divider: magnitude, overflow check, one stage per quotient bit, saturation
  localparam int DIV_LAT  = DATA_WIDTH + 3;
  localparam int PIPE_LAT = DIV_LAT + 4;

  typedef logic signed [DATA_WIDTH-1:0] ent_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [COF_W-1:0]      cof_t;
  typedef logic signed [DET_W-1:0]      det_t;
  typedef logic        [REM_W-1:0]      rem_t;
  typedef logic        [DATA_WIDTH-1:0] quo_t;

  // entry index = row*3 + col; cofactor k = m[a]*m[b] - m[c]*m[d]
  localparam int COF_SRC [NUM_ENT][4] = '{
    '{4, 8, 5, 7},
    '{2, 7, 1, 8},
    '{1, 5, 2, 4},
    '{5, 6, 3, 8},
    '{0, 8, 2, 6},
    '{3, 2, 0, 5},
    '{3, 7, 6, 4},
    '{1, 6, 0, 7},
    '{0, 4, 1, 3}
  };

endpackage

// ===== design/matrix3x3_inverse_core.sv =====
// 3x3 matrix inverse by the adjugate in signed Q16.16. One matrix per
// transaction in, one inverse per transaction out, in order. A new matrix is
// taken every cycle while the output side keeps up. The divider resolves
// one quotient bit per stage in nine parallel lanes. The whole pipeline holds
// when the output is stalled. The determinant and cofactors are exact; each
// entry is truncated toward zero and saturated. A zero determinant sets tuser
// and returns all-zero entries.
module matrix3x3_inverse_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up
  input  logic [mi3_pkg::TDATA_W-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22 from bit 0 up
  output logic [mi3_pkg::TDATA_W-1:0]   m_axis_tdata,
  // singular
  output logic                          m_axis_tuser
);
  import mi3_pkg::*;

  logic ce;
  logic vld [PIPE_LAT];
  logic sing_d [DIV_LAT];

  ent_t m     [NUM_ENT];
  cof_t cof_a [NUM_ENT];
  ent_t col0  [3];
  cof_t cof_b [NUM_ENT];
  det_t det;
  logic singular;
  ent_t quo   [NUM_ENT];

  assign ce            = !vld[PIPE_LAT-1] || m_axis_tready;
  assign s_axis_tready = ce;
  assign m_axis_tvalid = vld[PIPE_LAT-1];
  assign m_axis_tuser  = sing_d[DIV_LAT-1];

  always_comb begin
    for (int k = 0; k < NUM_ENT; k++) begin
      m[k] = s_axis_tdata[k*DATA_WIDTH +: DATA_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PIPE_LAT; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (ce) begin
      vld[0] <= s_axis_tvalid;
      for (int k = 1; k < PIPE_LAT; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sing_d[0] <= singular;
      for (int k = 1; k < DIV_LAT; k++) begin
        sing_d[k] <= sing_d[k-1];
      end
    end
  end

  mi3_cofactor u_cofactor (
    .clk  (clk),
    .ce   (ce),
    .m    (m),
    .cof  (cof_a),
    .col0 (col0)
  );

  mi3_det u_det (
    .clk      (clk),
    .ce       (ce),
    .cof      (cof_a),
    .col0     (col0),
    .cof_out  (cof_b),
    .det      (det),
    .singular (singular)
  );

  for (genvar k = 0; k < NUM_ENT; k++) begin : g_div
    mi3_div u_div (
      .clk (clk),
      .ce  (ce),
      .num (cof_b[k]),
      .den (det),
      .quo (quo[k])
    );
  end

  always_comb begin
    m_axis_tdata = '0;
    for (int k = 0; k < NUM_ENT; k++) begin
      m_axis_tdata[k*DATA_WIDTH +: DATA_WIDTH] = sing_d[DIV_LAT-1] ? '0 : quo[k];
    end
  end

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("singular result with nonzero entries");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> vld[0])
    else $error("accepted transaction not in first stage");

endmodule

// ===== design/mi3_cofactor.sv =====
module mi3_cofactor (
  input  logic            clk,
  input  logic            ce,
  input  mi3_pkg::ent_t   m      [mi3_pkg::NUM_ENT],
  output mi3_pkg::cof_t   cof    [mi3_pkg::NUM_ENT],
  output mi3_pkg::ent_t   col0   [3]
);
  import mi3_pkg::*;

  prod_t p_pos [NUM_ENT];
  prod_t p_neg [NUM_ENT];
  ent_t  col0_s1 [3];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < NUM_ENT; k++) begin
        p_pos[k] <= m[COF_SRC[k][0]] * m[COF_SRC[k][1]];
        p_neg[k] <= m[COF_SRC[k][2]] * m[COF_SRC[k][3]];
      end
      for (int k = 0; k < 3; k++) begin
        col0_s1[k] <= m[3*k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < NUM_ENT; k++) begin
        cof[k] <= COF_W'(p_pos[k]) - COF_W'(p_neg[k]);
      end
      col0 <= col0_s1;
    end
  end

endmodule

// ===== design/mi3_det.sv =====
module mi3_det (
  input  logic            clk,
  input  logic            ce,
  input  mi3_pkg::cof_t   cof      [mi3_pkg::NUM_ENT],
  input  mi3_pkg::ent_t   col0     [3],
  output mi3_pkg::cof_t   cof_out  [mi3_pkg::NUM_ENT],
  output mi3_pkg::det_t   det,
  output logic            singular
);
  import mi3_pkg::*;

  logic signed [PROD_W:0] plo [3];
  logic signed [PROD_W:0] phi [3];
  cof_t cof_s3 [NUM_ENT];
  det_t det_sum;

  // cofactor split into an unsigned low word and a signed high part
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        plo[k] <= col0[k] * $signed({1'b0, cof[k][DATA_WIDTH-1:0]});
        phi[k] <= col0[k] * $signed(cof[k][COF_W-1:DATA_WIDTH]);
      end
      cof_s3 <= cof;
    end
  end

  always_comb begin
    det_sum = '0;
    for (int k = 0; k < 3; k++) begin
      det_sum = det_sum + (DET_W'(phi[k]) <<< DATA_WIDTH) + DET_W'(plo[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      det      <= det_sum;
      singular <= (det_sum == '0);
      cof_out  <= cof_s3;
    end
  end

endmodule

// ===== design/mi3_div.sv =====
module mi3_div (
  input  logic           clk,
  input  logic           ce,
  input  mi3_pkg::cof_t  num,
  input  mi3_pkg::det_t  den,
  output mi3_pkg::ent_t  quo
);
  import mi3_pkg::*;

  localparam quo_t NEG_LIM = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam ent_t MAX_V   = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam ent_t MIN_V   = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic [COF_W-1:0] nabs;
  logic [DET_W-1:0] dabs;
  rem_t nmag_a;
  rem_t dmag_a;
  logic neg_a;

  rem_t r   [DATA_WIDTH+1];
  rem_t d   [DATA_WIDTH+1];
  quo_t q   [DATA_WIDTH+1];
  logic neg [DATA_WIDTH+1];
  logic ovf [DATA_WIDTH+1];

  always_comb begin
    nabs = num[COF_W-1] ? COF_W'(-num) : COF_W'(num);
    dabs = den[DET_W-1] ? DET_W'(-den) : DET_W'(den);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      nmag_a <= REM_W'(nabs) << (2 * FRAC_BITS);
      dmag_a <= REM_W'(dabs);
      neg_a  <= num[COF_W-1] ^ den[DET_W-1];
    end
  end

  // quotient at or above 2^DATA_WIDTH saturates regardless of low bits
  always_ff @(posedge clk) begin
    if (ce) begin
      ovf[0] <= (nmag_a >= (dmag_a << DATA_WIDTH));
      r[0]   <= nmag_a;
      d[0]   <= dmag_a;
      q[0]   <= '0;
      neg[0] <= neg_a;
    end
  end

  for (genvar j = 0; j < DATA_WIDTH; j++) begin : g_step
    localparam int BIT = DATA_WIDTH - 1 - j;
    rem_t trial;
    logic ge;

    always_comb begin
      trial = d[j] << BIT;
      ge    = (r[j] >= trial);
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        r[j+1]   <= ge ? r[j] - trial : r[j];
        q[j+1]   <= q[j] | (quo_t'(ge) << BIT);
        d[j+1]   <= d[j];
        neg[j+1] <= neg[j];
        ovf[j+1] <= ovf[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      if (neg[DATA_WIDTH]) begin
        if (ovf[DATA_WIDTH] || q[DATA_WIDTH] > NEG_LIM) begin
          quo <= MIN_V;
        end else begin
          quo <= ent_t'(-q[DATA_WIDTH]);
        end
      end else begin
        if (ovf[DATA_WIDTH] || q[DATA_WIDTH][DATA_WIDTH-1]) begin
          quo <= MAX_V;
        end else begin
          quo <= ent_t'(q[DATA_WIDTH]);
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import mi3_pkg::*;

  localparam int W = DATA_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int TW = TDATA_W;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef logic signed [W-1:0] entry_arr_t [NUM_ENT];
  typedef struct {
    logic [TW-1:0] data;
    logic          sing;
  } inverse_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [TW-1:0] s_axis_tdata = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [TW-1:0] m_axis_tdata;
  logic          m_axis_tuser;

  inverse_t expected_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int n_singular = 0;
  int n_saturated = 0;
  int idle_cycles = 0;
  bit hold_sink = 1'b0;
  bit sink_busy_mode = 1'b1;

  matrix3x3_inverse_core uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // exact adjugate divided by the exact determinant, truncated and saturated
  function automatic inverse_t predict_inverse(input logic [TW-1:0] mat);
    logic signed [W-1:0]   m [NUM_ENT];
    logic signed [255:0]   cof [NUM_ENT];
    logic signed [255:0]   det, num, quo;
    logic signed [255:0]   lim_hi, lim_lo;
    inverse_t              r;
    for (int i = 0; i < NUM_ENT; i++) m[i] = mat[i*W +: W];
    cof[0] = 256'(m[4]) * 256'(m[8]) - 256'(m[5]) * 256'(m[7]);
    cof[1] = 256'(m[2]) * 256'(m[7]) - 256'(m[1]) * 256'(m[8]);
    cof[2] = 256'(m[1]) * 256'(m[5]) - 256'(m[2]) * 256'(m[4]);
    cof[3] = 256'(m[5]) * 256'(m[6]) - 256'(m[3]) * 256'(m[8]);
    cof[4] = 256'(m[0]) * 256'(m[8]) - 256'(m[2]) * 256'(m[6]);
    cof[5] = 256'(m[3]) * 256'(m[2]) - 256'(m[0]) * 256'(m[5]);
    cof[6] = 256'(m[3]) * 256'(m[7]) - 256'(m[6]) * 256'(m[4]);
    cof[7] = 256'(m[1]) * 256'(m[6]) - 256'(m[0]) * 256'(m[7]);
    cof[8] = 256'(m[0]) * 256'(m[4]) - 256'(m[1]) * 256'(m[3]);
    det = 256'(m[0]) * cof[0] + 256'(m[3]) * cof[1] + 256'(m[6]) * cof[2];
    lim_hi = (256'sd1 <<< (W - 1)) - 1;
    lim_lo = -(256'sd1 <<< (W - 1));
    r.data = '0;
    r.sing = (det == 0);
    if (!r.sing) begin
      for (int i = 0; i < NUM_ENT; i++) begin
        num = cof[i] <<< (2 * FB);
        quo = num / det;  // SV signed division truncates toward zero
        if (quo > lim_hi) quo = lim_hi;
        if (quo < lim_lo) quo = lim_lo;
        r.data[i*W +: W] = quo[W-1:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int idx,
                                 input logic [W-1:0] got, input logic [W-1:0] want);
    errors++;
    $display("ERROR t=%0t result %0d %s: got %h want %h", $realtime, idx, what, got, want);
  endtask

  function automatic int pick_gap();
    int p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // valid drops only for the idle gap in front of an item
  task automatic send_matrix(input logic [TW-1:0] mat, input int gap);
    inverse_t exp_r;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= mat;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    exp_r = predict_inverse(mat);
    expected_q.push_back(exp_r);
    if (exp_r.sing) n_singular++;
    n_sent++;
  endtask

  function automatic logic [TW-1:0] pack_matrix(input entry_arr_t e);
    logic [TW-1:0] v = '0;
    for (int i = 0; i < NUM_ENT; i++) v[i*W +: W] = e[i];
    return v;
  endfunction

  task automatic send_one(input entry_arr_t e, input int gap);
    send_matrix(pack_matrix(e), gap);
  endtask

  function automatic logic [W-1:0] q16(input int v);
    return W'(v) << FB;
  endfunction

  function automatic logic [W-1:0] rand_entry(input int style);
    case (style)
      0: return $urandom();
      1: return q16($urandom_range(0, 20)) - q16(10) + W'($urandom_range(0, 65535));
      2: return $urandom_range(0, 1) ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      default: return W'($signed($urandom_range(0, 16)) - 8);
    endcase
  endfunction

  task automatic test_directed();
    entry_arr_t e;
    // identity and scaled identity
    e = '{q16(1), 0, 0, 0, q16(1), 0, 0, 0, q16(1)};        send_one(e, 0);
    e = '{q16(2), 0, 0, 0, q16(-4), 0, 0, 0, q16(8)};       send_one(e, 1);
    // all zero and rank-deficient: singular
    e = '{default: '0};                                      send_one(e, 0);
    e = '{q16(1), q16(2), q16(3), q16(2), q16(4), q16(6), q16(7), q16(8), q16(9)};
    send_one(e, 2);
    e = '{default: 32'h8000_0000};                           send_one(e, 0);
    e = '{default: 32'h7fff_ffff};                           send_one(e, 0);
    // extreme diagonal: tiny det saturates, huge det gives entries near zero
    e = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                        send_one(e, 0);
    e = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};                       send_one(e, 0);
    e = '{32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h8000_0000};
    send_one(e, 0);
    e = '{32'h7fff_ffff, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h7fff_ffff};
    send_one(e, 3);
    e = '{32'h7fff_ffff, 32'h8000_0000, 1, -1, 32'h7fff_ffff, 0, 5, 32'h8000_0000, -7};
    send_one(e, 0);
    e = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};               send_one(e, 0);
    e = '{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
          32'h1234_5678, 32'hedcb_a987, 32'h0f0f_0f0f, 32'hf0f0_f0f0};
    send_one(e, 0);
    // permutation and rotation-like
    e = '{0, q16(1), 0, 0, 0, q16(1), q16(1), 0, 0};         send_one(e, 0);
    e = '{0, q16(-1), 0, q16(1), 0, 0, 0, 0, q16(1)};        send_one(e, 0);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic test_random(input int count, input int style_mask);
    entry_arr_t e;
    int st;
    for (int k = 0; k < count; k++) begin
      st = $urandom_range(0, 3);
      if (!style_mask[st]) st = 1;
      for (int i = 0; i < NUM_ENT; i++) e[i] = rand_entry(st);
      // sometimes force a duplicated row so singular cases stay frequent
      if ($urandom_range(0, 9) == 0) for (int i = 0; i < 3; i++) e[6+i] = e[i];
      send_matrix(pack_matrix(e), (k == count - 1) ? 1 : pick_gap());
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // sink stalls for a long stretch while the source keeps streaming
  task automatic test_backpressure();
    hold_sink = 1'b1;
    fork
      begin
        entry_arr_t e;
        for (int k = 0; k < 120; k++) begin
          for (int i = 0; i < NUM_ENT; i++) e[i] = rand_entry(1);
          send_matrix(pack_matrix(e), (k == 119) ? 1 : 0);
        end
        s_axis_tvalid <= 1'b0;
      end
      begin
        repeat (300) @(posedge clk);
        hold_sink = 1'b0;
      end
    join
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
  endtask

  // output side: random ready, checked against the oldest expectation
  always @(posedge clk) begin
    inverse_t exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected", n_recv, '0, '0);
      end else begin
        exp_r = expected_q.pop_front();
        if (m_axis_tuser !== exp_r.sing)
          report_mismatch("singular", n_recv, W'(m_axis_tuser), W'(exp_r.sing));
        for (int i = 0; i < NUM_ENT; i++) begin
          if (m_axis_tdata[i*W +: W] !== exp_r.data[i*W +: W])
            report_mismatch($sformatf("r%0d%0d", i / 3, i % 3), n_recv,
                            m_axis_tdata[i*W +: W], exp_r.data[i*W +: W]);
          if (exp_r.data[i*W +: W] == {1'b0, {(W-1){1'b1}}} ||
              exp_r.data[i*W +: W] == {1'b1, {(W-1){1'b0}}})
            n_saturated++;
        end
      end
      n_recv++;
    end
  end

  int sink_gap = 0;
  always @(posedge clk) begin
    if (rst || hold_sink) begin
      m_axis_tready <= 1'b0;
    end else if (!sink_busy_mode) begin
      m_axis_tready <= 1'b1;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) sink_gap <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("matrix3x3_inverse_core regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    drain();
    test_backpressure();
    drain();
    sink_busy_mode = 1'b0;
    test_random(300, 4'b0010);
    drain();
    sink_busy_mode = 1'b1;
    test_random(600, 4'b1111);
    drain();
    $display("sent %0d matrices, checked %0d inverses (%0d singular, %0d saturated entries)",
             n_sent, n_recv, n_singular, n_saturated);
    $display("covered extremes, singular inputs, long output stall and random idling");
    if (errors == 0)
      $display("matrix3x3_inverse_core regression: pass");
    else
      $display("matrix3x3_inverse_core regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mi3_pkg.sv
design/mi3_cofactor.sv
design/mi3_det.sv
design/mi3_div.sv
design/matrix3x3_inverse_core.sv
tb/sv/tb.sv
